@@ hdl/k_way_sorted_merge_core_assert.svh @@
// Assertion macros for the k-way merge core.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef K_WAY_SORTED_MERGE_CORE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on a named clock, disabled while the named reset is low.
`define KWM_ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on the core clock and reset.
`define KWM_ASSERT(lbl, prop, msg) \
    `KWM_ASSERT_CLKD(lbl, i_clk, i_rst_n, prop, msg)
`else
`define KWM_ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define KWM_ASSERT(lbl, prop, msg)
`endif

`endif

@@ hdl/kwm_pkg.sv @@
// Shared types and constants of the k-way merge core.
// No dependencies.
`timescale 1ns / 1ps

package kwm_pkg;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_POP_RD = 2'd1,
        S_POP_WB = 2'd2
    } t_state;

endpackage

@@ hdl/kwm_if.sv @@
// Request and response channel interfaces of the k-way merge core.
// Depends on kwm_pkg for field widths.
`timescale 1ns / 1ps

interface kwm_req_if;
    logic                                valid;
    logic                                ready;
    logic        [kwm_pkg::OPCODE_W-1:0] opcode;
    logic        [kwm_pkg::INDEX_W-1:0]  list_index;
    logic signed [kwm_pkg::VALUE_W-1:0]  value;

    modport source (output valid, opcode, list_index, value, input ready);
    modport sink   (input valid, opcode, list_index, value, output ready);
endinterface

interface kwm_rsp_if;
    logic                                valid;
    logic                                ready;
    logic        [kwm_pkg::STATUS_W-1:0] status;
    logic signed [kwm_pkg::VALUE_W-1:0]  merged_value;
    logic        [kwm_pkg::INDEX_W-1:0]  source_list;

    modport source (output valid, status, merged_value, source_list, input ready);
    modport sink   (input valid, status, merged_value, source_list, output ready);
endinterface

@@ hdl/k_way_sorted_merge_core.sv @@
// K-way merge core: bounded FIFO lists in one RAM, heads cached in registers.
// Depends on kwm_pkg, kwm_if, kwm_store_ram, kwm_head_select and the assert header.
//
//  channel | dir | payload                              | accept
//  i_req   | in  | opcode, list_index, value            | valid & ready
//  o_rsp   | out | status, merged_value, source_list    | valid & ready
//
// Append, clear and no-op finish from the idle state; pop passes through S_POP_RD,
// and then S_POP_WB when the popped list still holds entries and its new head is read
// back from the RAM.
// Reset is synchronous and active low; it empties every list, RAM contents are kept.
// A stalled response holds in the output register; while idle, a new request is taken in the
// cycle the pending response leaves.
`timescale 1ns / 1ps
`include "k_way_sorted_merge_core_assert.svh"

module k_way_sorted_merge_core #(
    parameter int NUM_LISTS  = 8,
    parameter int LIST_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kwm_req_if.sink    i_req,
    kwm_rsp_if.source  o_rsp
);

    localparam int LW    = $clog2(NUM_LISTS);
    localparam int SW    = $clog2(LIST_DEPTH);
    localparam int CW    = $clog2(LIST_DEPTH + 1);
    localparam int AW    = LW + SW;
    localparam int EXT_W = ((LW > kwm_pkg::INDEX_W) ? LW : kwm_pkg::INDEX_W) + 1;
    localparam int VW    = kwm_pkg::VALUE_W;

    kwm_pkg::t_state r_state, n_state;

    logic [SW-1:0]        r_hp   [NUM_LISTS];
    logic [CW-1:0]        r_cnt  [NUM_LISTS];
    logic signed [VW-1:0] r_head [NUM_LISTS];

    logic                 r_best_found;
    logic [LW-1:0]        r_best_idx;
    logic signed [VW-1:0] r_best_val;

    logic                          r_out_valid;
    logic [kwm_pkg::STATUS_W-1:0]  r_out_status;
    logic signed [VW-1:0]          r_out_value;
    logic [kwm_pkg::INDEX_W-1:0]   r_out_source;

    logic                 req_ready;
    logic                 req_fire;
    kwm_pkg::t_opcode     req_op;
    logic [EXT_W-1:0]     idx_ext;
    logic [LW-1:0]        req_list;
    logic                 idx_ok;
    logic                 list_full;
    logic [SW:0]          tail_sum;
    logic [SW-1:0]        tail_slot;
    logic                 app_ok;

    logic [NUM_LISTS-1:0] head_valid;
    logic                 sel_found;
    logic [LW-1:0]        sel_idx;
    logic signed [VW-1:0] sel_val;

    logic [SW-1:0]        best_hp;
    logic [SW-1:0]        best_next_hp;
    logic [EXT_W-1:0]     best_ext;
    logic [VW-1:0]        rd_data;

    // decode the request
    assign req_fire  = i_req.valid && req_ready;
    assign req_op    = kwm_pkg::t_opcode'(i_req.opcode);
    assign idx_ext   = EXT_W'(i_req.list_index);
    assign req_list  = idx_ext[LW-1:0];
    assign idx_ok    = idx_ext < EXT_W'(NUM_LISTS);
    assign list_full = idx_ok ? (r_cnt[req_list] >= CW'(LIST_DEPTH)) : 1'b1;
    assign app_ok    = req_fire && (req_op == kwm_pkg::OP_APPEND) && !list_full;

    // tail slot of the target list, wrapped once
    always_comb begin
        tail_sum = {1'b0, r_hp[req_list]} + (SW + 1)'(r_cnt[req_list]);
        if (tail_sum >= (SW + 1)'(LIST_DEPTH)) begin
            tail_sum = tail_sum - (SW + 1)'(LIST_DEPTH);
        end
        tail_slot = tail_sum[SW-1:0];
    end

    // head pointer after the pop of the selected list
    assign best_hp      = r_hp[r_best_idx];
    assign best_next_hp = (best_hp == SW'(LIST_DEPTH - 1)) ? '0 : best_hp + SW'(1);
    assign best_ext     = EXT_W'(r_best_idx);

    for (genvar g = 0; g < NUM_LISTS; g++) begin : g_vld
        assign head_valid[g] = (r_cnt[g] != '0);
    end

    kwm_head_select #(
        .NUM_LISTS (NUM_LISTS),
        .LIST_W    (LW)
    ) u_select (
        .i_valid (head_valid),
        .i_value (r_head),
        .o_found (sel_found),
        .o_index (sel_idx),
        .o_value (sel_val)
    );

    kwm_store_ram #(
        .ADDR_W (AW),
        .DATA_W (VW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (app_ok),
        .i_wr_addr ({req_list, tail_slot}),
        .i_wr_data (i_req.value),
        .i_rd_en   (r_state == kwm_pkg::S_POP_RD),
        .i_rd_addr ({r_best_idx, best_next_hp}),
        .o_rd_data (rd_data)
    );

    // next state and request ready
    always_comb begin
        n_state   = r_state;
        req_ready = 1'b0;
        case (r_state)
            kwm_pkg::S_IDLE: begin
                req_ready = !r_out_valid || o_rsp.ready;
                if (i_req.valid && req_ready && (req_op == kwm_pkg::OP_POP)) begin
                    n_state = kwm_pkg::S_POP_RD;
                end
            end
            kwm_pkg::S_POP_RD: begin
                if (r_best_found && (r_cnt[r_best_idx] > CW'(1))) begin
                    n_state = kwm_pkg::S_POP_WB;
                end else begin
                    n_state = kwm_pkg::S_IDLE;
                end
            end
            kwm_pkg::S_POP_WB: begin
                n_state = kwm_pkg::S_IDLE;
            end
            default: begin
                n_state = kwm_pkg::S_IDLE;
            end
        endcase
    end

    assign i_req.ready = req_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kwm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // list pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LISTS; k++) begin
                r_hp[k]  <= '0;
                r_cnt[k] <= '0;
            end
        end else if (req_fire && (req_op == kwm_pkg::OP_CLEAR)) begin
            for (int k = 0; k < NUM_LISTS; k++) begin
                r_hp[k]  <= '0;
                r_cnt[k] <= '0;
            end
        end else if (app_ok) begin
            r_cnt[req_list] <= r_cnt[req_list] + CW'(1);
        end else if ((r_state == kwm_pkg::S_POP_RD) && r_best_found) begin
            r_hp[r_best_idx]  <= best_next_hp;
            r_cnt[r_best_idx] <= r_cnt[r_best_idx] - CW'(1);
        end
    end

    // head cache: write through on append to an empty list, refill after pop
    always_ff @(posedge i_clk) begin
        if (app_ok && (r_cnt[req_list] == '0)) begin
            r_head[req_list] <= i_req.value;
        end
        if (r_state == kwm_pkg::S_POP_WB) begin
            r_head[r_best_idx] <= $signed(rd_data);
        end
    end

    // capture the winning head whenever a request is taken; only a pop uses it
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_best_found <= sel_found;
            r_best_idx   <= sel_idx;
            r_best_val   <= sel_val;
        end
    end

    // response register: hold until the sink takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req_fire && (req_op != kwm_pkg::OP_POP)) begin
            r_out_valid <= 1'b1;
        end else if (r_state == kwm_pkg::S_POP_RD) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire && (req_op != kwm_pkg::OP_POP)) begin
            r_out_value  <= '0;
            r_out_source <= '0;
            if ((req_op == kwm_pkg::OP_APPEND) && list_full) begin
                r_out_status <= kwm_pkg::ST_FULL;
            end else begin
                r_out_status <= kwm_pkg::ST_OK;
            end
        end else if (r_state == kwm_pkg::S_POP_RD) begin
            if (r_best_found) begin
                r_out_status <= kwm_pkg::ST_OK;
                r_out_value  <= r_best_val;
                r_out_source <= best_ext[kwm_pkg::INDEX_W-1:0];
            end else begin
                r_out_status <= kwm_pkg::ST_EMPTY;
                r_out_value  <= '0;
                r_out_source <= '0;
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.merged_value = r_out_value;
    assign o_rsp.source_list  = r_out_source;

    // checks
    `KWM_ASSERT(a_pop_enters_read, (req_fire && (req_op == kwm_pkg::OP_POP)) |=> (r_state == kwm_pkg::S_POP_RD), "accepted pop did not start the head read")
    `KWM_ASSERT(a_wb_after_read, (r_state == kwm_pkg::S_POP_WB) |-> ($past(r_state) == kwm_pkg::S_POP_RD), "head refill without a preceding read")
    `KWM_ASSERT(a_popped_list_nonempty, ((r_state == kwm_pkg::S_POP_RD) && r_best_found) |-> (r_cnt[r_best_idx] != '0), "pop selected an empty list")
    `KWM_ASSERT(a_empty_has_zero_payload, (r_out_valid && (r_out_status == kwm_pkg::ST_EMPTY)) |-> ((r_out_value == '0) && (r_out_source == '0)), "empty pop response carries data")

endmodule

@@ hdl/kwm_store_ram.sv @@
// List storage RAM: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps

module kwm_store_ram #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [1 << ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/kwm_head_select.sv @@
// Minimum tree over the cached list heads; lowest index wins a tie.
// Depends on kwm_pkg for the value width.
`timescale 1ns / 1ps

module kwm_head_select #(
    parameter int NUM_LISTS = 8,
    parameter int LIST_W    = 3
) (
    input  logic [NUM_LISTS-1:0]                    i_valid,
    input  logic signed [kwm_pkg::VALUE_W-1:0]      i_value [NUM_LISTS],
    output logic                                    o_found,
    output logic [LIST_W-1:0]                       o_index,
    output logic signed [kwm_pkg::VALUE_W-1:0]      o_value
);

    localparam int LEAVES = 1 << LIST_W;
    localparam int NODES  = 2 * LEAVES - 1;

    logic                               node_vld [NODES];
    logic [LIST_W-1:0]                  node_idx [NODES];
    logic signed [kwm_pkg::VALUE_W-1:0] node_val [NODES];

    // load leaves; padding leaves stay invalid
    for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
        if (l < NUM_LISTS) begin : g_used
            assign node_vld[LEAVES-1+l] = i_valid[l];
            assign node_val[LEAVES-1+l] = i_value[l];
        end else begin : g_pad
            assign node_vld[LEAVES-1+l] = 1'b0;
            assign node_val[LEAVES-1+l] = '0;
        end
        assign node_idx[LEAVES-1+l] = LIST_W'(l);
    end

    // combine pairs; the left child holds the lower indices
    for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
        logic take_left;
        assign take_left = node_vld[2*n+1] &&
                           (!node_vld[2*n+2] || (node_val[2*n+1] <= node_val[2*n+2]));
        assign node_vld[n] = node_vld[2*n+1] || node_vld[2*n+2];
        assign node_idx[n] = take_left ? node_idx[2*n+1] : node_idx[2*n+2];
        assign node_val[n] = take_left ? node_val[2*n+1] : node_val[2*n+2];
    end

    assign o_found = node_vld[0];
    assign o_index = node_idx[0];
    assign o_value = node_val[0];

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for k_way_sorted_merge_core: directed and random append/pop/clear traffic.
// Depends on kwm_pkg, kwm_if and the core RTL; holds its own model of the lists.
`timescale 1ns / 1ps

import kwm_pkg::*;

// Track list contents and queue the expected response of every accepted request
class merge_scoreboard;
    localparam int LISTS = 8;
    localparam int DEPTH = 16;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] merged_value;
        logic [2:0]         source_list;
    } merge_result_t;

    logic signed [31:0] list_word [LISTS][DEPTH];
    logic [3:0]         head_ptr  [LISTS];
    logic [4:0]         fill_cnt  [LISTS];
    merge_result_t      expected_q [$];
    int                 fail_count;

    function new();
        empty_lists();
        fail_count = 0;
    endfunction

    function void empty_lists();
        foreach (head_ptr[i]) begin
            head_ptr[i] = '0;
            fill_cnt[i] = '0;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Apply one accepted request to the lists and queue its response
    function void note_request(t_opcode op, logic [2:0] idx, logic signed [31:0] val);
        merge_result_t      res;
        logic [3:0]         slot;
        bit                 found;
        int                 best;
        logic signed [31:0] best_val;
        logic signed [31:0] head_word;
        res.status       = ST_OK;
        res.merged_value = '0;
        res.source_list  = '0;
        found            = 1'b0;
        best             = 0;
        best_val         = '0;
        case (op)
            OP_APPEND: begin
                if (fill_cnt[idx] >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot = head_ptr[idx] + fill_cnt[idx][3:0];
                    list_word[idx][slot] = val;
                    fill_cnt[idx] = fill_cnt[idx] + 5'd1;
                end
            end
            OP_POP: begin
                // Pick the smallest head; strict compare keeps the lowest index on ties
                for (int i = 0; i < LISTS; i++) begin
                    if (fill_cnt[i] != 0) begin
                        head_word = list_word[i][head_ptr[i]];
                        if (!found || head_word < best_val) begin
                            found    = 1'b1;
                            best     = i;
                            best_val = head_word;
                        end
                    end
                end
                if (!found) begin
                    res.status = ST_EMPTY;
                end else begin
                    head_ptr[best]   = head_ptr[best] + 4'd1;
                    fill_cnt[best]   = fill_cnt[best] - 5'd1;
                    res.merged_value = best_val;
                    res.source_list  = best[2:0];
                end
            end
            OP_CLEAR: empty_lists();
            default: ;
        endcase
        expected_q.push_back(res);
    endfunction

    // Compare one accepted response with the oldest expectation
    function void check_response(logic [1:0] status, logic signed [31:0] merged_value,
                                 logic [2:0] source_list);
        merge_result_t want;
        if (expected_q.size() == 0) begin
            $error("unexpected response transaction: status %0d merged_value %0d source_list %0d",
                   status, merged_value, source_list);
            fail_count++;
            return;
        end
        want = expected_q.pop_front();
        if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            fail_count++;
        end
        if (merged_value !== want.merged_value) begin
            $error("merged_value mismatch: expected %0d, actual %0d",
                   want.merged_value, merged_value);
            fail_count++;
        end
        if (source_list !== want.source_list) begin
            $error("source_list mismatch: expected %0d, actual %0d",
                   want.source_list, source_list);
            fail_count++;
        end
    endfunction
endclass

module testbench;
    localparam int ITEM_TARGET    = 1050;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 300;
    localparam int CALM_FIRST     = 600;
    localparam int CALM_LAST      = 800;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kwm_req_if req_ch ();
    kwm_rsp_if rsp_ch ();

    merge_scoreboard sb;
    int              items_sent   = 0;
    int              stall_cycles = 0;

    k_way_sorted_merge_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic bit calm_stretch();
        return items_sent >= CALM_FIRST && items_sent < CALM_LAST;
    endfunction

    // Mix extremes, a narrow band that produces ties, and full-range words
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4, 5, 6: return $signed(32'($urandom_range(200))) - 32'sd100;
            default: return $signed($urandom);
        endcase
    endfunction

    // Offer one request and hold it until the core takes it
    task automatic send_item(input t_opcode op, input logic [2:0] idx,
                             input logic signed [31:0] val);
        if (!calm_stretch()) begin
            while ($urandom_range(99) < 20) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.list_index <= idx;
        req_ch.value      <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Check responses first so a same-edge request queues behind them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.merged_value, rsp_ch.source_list);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(t_opcode'(req_ch.opcode), req_ch.list_index, req_ch.value);
        end
    end

    // Abort when no transaction moves on either channel for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Response side: random back-pressure, one long hold-off to fill the core
    initial begin : response_sink
        bit held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && items_sent >= HOLD_AT) begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            rsp_ch.ready <= calm_stretch() || ($urandom_range(99) >= 20);
        end
    end

    initial begin : stimulus
        logic [2:0]         idx;
        logic signed [31:0] val;
        int                 run_lists;
        int                 run_len;
        int                 step;
        int                 total;

        sb = new();
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_NOP;
        req_ch.list_index <= '0;
        req_ch.value      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pop, no-op, extremes, tie on equal heads, clear
        send_item(OP_POP, 3'd0, 32'sd0);
        send_item(OP_NOP, 3'd7, -32'sd1);
        send_item(OP_APPEND, 3'd0, 32'sh7fff_ffff);
        send_item(OP_APPEND, 3'd7, 32'sh8000_0000);
        send_item(OP_APPEND, 3'd3, 32'sd5);
        send_item(OP_APPEND, 3'd5, 32'sd5);
        send_item(OP_APPEND, 3'd3, 32'sd6);
        repeat (6) send_item(OP_POP, 3'd2, 32'sd0);
        send_item(OP_APPEND, 3'd2, -32'sd1);
        send_item(OP_APPEND, 3'd6, 32'sd0);
        send_item(OP_CLEAR, 3'd1, 32'sd0);
        send_item(OP_POP, 3'd0, 32'sd0);
        send_item(OP_APPEND, 3'd1, 32'sd0);
        send_item(OP_APPEND, 3'd4, -32'sd1);
        repeat (3) send_item(OP_POP, 3'd5, 32'sd0);

        // Random: mostly merge rounds of ascending runs, some fills past full, some noise
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    run_lists = $urandom_range(2, 8);
                    total = 0;
                    repeat (run_lists) begin
                        idx     = 3'($urandom_range(7));
                        run_len = $urandom_range(1, 6);
                        step    = $urandom_range(0, 3);
                        val     = pick_value();
                        repeat (run_len) begin
                            send_item(OP_APPEND, idx, val);
                            val = val + step;
                        end
                        total += run_len;
                    end
                    repeat (total + $urandom_range(0, 2))
                        send_item(OP_POP, 3'($urandom_range(7)), pick_value());
                end
                6, 7: begin
                    idx = 3'($urandom_range(7));
                    val = $signed(32'($urandom_range(1000))) - 32'sd500;
                    repeat ($urandom_range(14, 18)) begin
                        send_item(OP_APPEND, idx, val);
                        val = val + $urandom_range(0, 2);
                    end
                    if ($urandom_range(1))
                        send_item(OP_CLEAR, 3'($urandom_range(7)), pick_value());
                    else
                        repeat ($urandom_range(0, 20))
                            send_item(OP_POP, 3'($urandom_range(7)), pick_value());
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        send_item(t_opcode'($urandom_range(3)), 3'($urandom_range(7)),
                                  pick_value());
                end
            endcase
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding responses, then let the pipeline settle
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
